>>> src/hhxm_pkg.sv
package hhxm_pkg;

    localparam int HEADING_W = 9;
    localparam int GAIN_W    = 8;
    localparam int CMD_W     = 9;
    localparam int DB_W      = 8;
    localparam int BYTE_W    = 8;
    localparam int ERR_W     = 9;
    localparam int PROP_W    = 17;
    localparam int DUTY_W    = 8;
    localparam int DIR_W     = 8;
    localparam int SPD_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;

    localparam int SPEED_LIMIT = 255;
    localparam int LOW_LIMIT   = -255;
    localparam int DUTY_MAX    = 255;
    localparam int HEADING_MAX = 360;
    localparam int HALF_TURN   = 180;
    localparam int FULL_TURN   = 360;
    localparam int HIGH_OFFSET = 255;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEADING    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROPORTIONAL_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_COMMAND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIDEWAYS_COMMAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND          = 3'd4;

    localparam logic [HEADING_W-1:0] RST_TARGET_HEADING    = 9'd0;
    localparam logic [GAIN_W-1:0]    RST_PROPORTIONAL_GAIN = 8'd3;
    localparam logic [CMD_W-1:0]     RST_FORWARD_COMMAND   = 9'd100;
    localparam logic [CMD_W-1:0]     RST_SIDEWAYS_COMMAND  = 9'd0;
    localparam logic [DB_W-1:0]      RST_DEADBAND          = 8'd5;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [1:0]        dir;
    } wheel_out_t;

endpackage

>>> src/hhxm_wheel.sv
module hhxm_wheel (
    input  logic signed [hhxm_pkg::SPD_W-1:0] speed_raw,
    input  logic [hhxm_pkg::DB_W-1:0]         deadband,
    input  logic [1:0]                        dir_old,
    output hhxm_pkg::wheel_out_t              wheel_out
);

    localparam logic signed [hhxm_pkg::SPD_W-1:0] SPD_HI =
        hhxm_pkg::SPD_W'(hhxm_pkg::SPEED_LIMIT);
    localparam logic signed [hhxm_pkg::SPD_W-1:0] SPD_LO =
        hhxm_pkg::SPD_W'(hhxm_pkg::LOW_LIMIT);
    localparam logic [hhxm_pkg::SPD_W-1:0] MAG_MAX =
        hhxm_pkg::SPD_W'(hhxm_pkg::DUTY_MAX);

    logic signed [hhxm_pkg::SPD_W-1:0] speed;
    logic signed [hhxm_pkg::SPD_W-1:0] db_pos;
    logic signed [hhxm_pkg::SPD_W-1:0] db_neg;
    logic [hhxm_pkg::SPD_W-1:0]        mag;

    always_comb begin
        if (speed_raw > SPD_HI) begin
            speed = SPD_HI;
        end else if (speed_raw < SPD_LO) begin
            speed = SPD_LO;
        end else begin
            speed = speed_raw;
        end
        db_pos = $signed({{(hhxm_pkg::SPD_W-hhxm_pkg::DB_W){1'b0}}, deadband});
        db_neg = -db_pos;
        mag    = speed[hhxm_pkg::SPD_W-1] ? $unsigned(-speed) : $unsigned(speed);

        // bit 0 forward, bit 1 reverse; keep inside the deadband
        if (speed > db_pos) begin
            wheel_out.dir = 2'b01;
        end else if (speed < db_neg) begin
            wheel_out.dir = 2'b10;
        end else begin
            wheel_out.dir = dir_old;
        end
        wheel_out.duty = (mag > MAG_MAX) ? hhxm_pkg::DUTY_W'(hhxm_pkg::DUTY_MAX)
                                         : mag[hhxm_pkg::DUTY_W-1:0];
    end

endmodule

>>> src/heading_hold_xdrive_mixer_unit.sv
// Heading-hold mixer for a four-wheel X drive. Each item carries two heading
// bytes; the block decodes a heading, forms the wrapped target-minus-heading
// error, the proportional term and four clamped wheel duties with direction
// bits. An item is accepted whenever s_ready is high: it lands in an input
// register and moves on into the output register once that register is free
// or its result is taken, so the throughput is one item per cycle while
// m_ready stays high. The stored heading and the wheel direction bits
// advance as each item moves into the output register. Configuration writes
// take effect at once and belong to idle periods only.
module heading_hold_xdrive_mixer_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_wr_en,
    input  logic [hhxm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hhxm_pkg::CFG_DAT_W-1:0]         cfg_wdata,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [hhxm_pkg::BYTE_W-1:0]            s_first_byte,
    input  logic [hhxm_pkg::BYTE_W-1:0]            s_second_byte,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [hhxm_pkg::ERR_W-1:0]      m_heading_error,
    output logic signed [hhxm_pkg::PROP_W-1:0]     m_proportional_term,
    output logic [hhxm_pkg::DUTY_W-1:0]            m_duty_top_left,
    output logic [hhxm_pkg::DUTY_W-1:0]            m_duty_top_right,
    output logic [hhxm_pkg::DUTY_W-1:0]            m_duty_bottom_left,
    output logic [hhxm_pkg::DUTY_W-1:0]            m_duty_bottom_right,
    output logic [hhxm_pkg::DIR_W-1:0]             m_direction_bits
);

    localparam int HW = hhxm_pkg::HEADING_W;
    localparam int EW = hhxm_pkg::HEADING_W + 1;
    localparam int SW = hhxm_pkg::SPD_W;

    localparam logic [HW-1:0] HEAD_MAX = HW'(hhxm_pkg::HEADING_MAX);
    localparam logic [HW-1:0] HEAD_OFS = HW'(hhxm_pkg::HIGH_OFFSET);
    localparam logic signed [EW-1:0] E_HALF = EW'(hhxm_pkg::HALF_TURN);
    localparam logic signed [EW-1:0] E_FULL = EW'(hhxm_pkg::FULL_TURN);

    // configuration
    logic [hhxm_pkg::HEADING_W-1:0] target_heading_reg;
    logic [hhxm_pkg::GAIN_W-1:0]    proportional_gain_reg;
    logic [hhxm_pkg::CMD_W-1:0]     forward_command_reg;
    logic [hhxm_pkg::CMD_W-1:0]     sideways_command_reg;
    logic [hhxm_pkg::DB_W-1:0]      deadband_reg;

    // state
    logic [HW-1:0]                  last_heading_reg;
    logic [HW-1:0]                  last_heading_next;
    logic [hhxm_pkg::DIR_W-1:0]     wheel_dir_reg;
    logic [hhxm_pkg::DIR_W-1:0]     wheel_dir_next;

    // input stage
    logic                           in_valid_reg;
    logic [hhxm_pkg::BYTE_W-1:0]    first_byte_reg;
    logic [hhxm_pkg::BYTE_W-1:0]    second_byte_reg;

    // output stage
    logic                           out_valid_reg;
    logic signed [hhxm_pkg::ERR_W-1:0]  err_reg;
    logic signed [hhxm_pkg::PROP_W-1:0] prop_reg;
    logic [hhxm_pkg::DUTY_W-1:0]    duty_reg [4];

    logic                           out_load;
    logic                           in_load;

    logic [HW-1:0]                  heading_dec;
    logic [HW-1:0]                  target_sat;
    logic signed [EW-1:0]           err_raw;
    logic signed [EW-1:0]           err_wrap;
    logic signed [hhxm_pkg::ERR_W-1:0] err_next;
    logic signed [2*hhxm_pkg::ERR_W-1:0] prop_full;
    logic signed [SW-1:0]           fwd_ext;
    logic signed [SW-1:0]           side_ext;
    logic signed [SW-1:0]           err_ext;
    logic signed [SW-1:0]           speed_raw [4];
    hhxm_pkg::wheel_out_t           wheel_out [4];

    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_heading_reg    <= hhxm_pkg::RST_TARGET_HEADING;
            proportional_gain_reg <= hhxm_pkg::RST_PROPORTIONAL_GAIN;
            forward_command_reg   <= hhxm_pkg::RST_FORWARD_COMMAND;
            sideways_command_reg  <= hhxm_pkg::RST_SIDEWAYS_COMMAND;
            deadband_reg          <= hhxm_pkg::RST_DEADBAND;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                hhxm_pkg::REG_TARGET_HEADING: begin
                    target_heading_reg <= cfg_wdata;
                end
                hhxm_pkg::REG_PROPORTIONAL_GAIN: begin
                    proportional_gain_reg <= cfg_wdata[hhxm_pkg::GAIN_W-1:0];
                end
                hhxm_pkg::REG_FORWARD_COMMAND: begin
                    forward_command_reg <= cfg_wdata;
                end
                hhxm_pkg::REG_SIDEWAYS_COMMAND: begin
                    sideways_command_reg <= cfg_wdata;
                end
                hhxm_pkg::REG_DEADBAND: begin
                    deadband_reg <= cfg_wdata[hhxm_pkg::DB_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (first_byte_reg != '0 && second_byte_reg == '0) begin
            heading_dec = {1'b0, first_byte_reg} + HEAD_OFS;
        end else if (first_byte_reg == '0 && second_byte_reg != '0) begin
            heading_dec = {1'b0, second_byte_reg};
        end else if (first_byte_reg == '0 && second_byte_reg == '0) begin
            heading_dec = '0;
        end else begin
            heading_dec = last_heading_reg;
        end
        last_heading_next = (heading_dec > HEAD_MAX) ? last_heading_reg : heading_dec;

        target_sat = (target_heading_reg > HEAD_MAX) ? HEAD_MAX : target_heading_reg;
        err_raw    = $signed({1'b0, target_sat}) - $signed({1'b0, last_heading_next});
        if (err_raw >= E_HALF) begin
            err_wrap = err_raw - E_FULL;
        end else if (err_raw <= -E_HALF) begin
            err_wrap = err_raw + E_FULL;
        end else begin
            err_wrap = err_raw;
        end
        err_next  = err_wrap[hhxm_pkg::ERR_W-1:0];
        prop_full = err_next * $signed({1'b0, proportional_gain_reg});

        fwd_ext  = SW'(signed'(forward_command_reg));
        side_ext = SW'(signed'(sideways_command_reg));
        err_ext  = SW'(err_next);
        speed_raw[0] =  fwd_ext + side_ext + err_ext;
        speed_raw[1] = -fwd_ext + side_ext + err_ext;
        speed_raw[2] =  fwd_ext - side_ext + err_ext;
        speed_raw[3] = -fwd_ext - side_ext + err_ext;
    end

    for (genvar w = 0; w < 4; w++) begin : g_wheel
        hhxm_wheel u_wheel (
            .speed_raw (speed_raw[w]),
            .deadband  (deadband_reg),
            .dir_old   (wheel_dir_reg[2*w +: 2]),
            .wheel_out (wheel_out[w])
        );
        assign wheel_dir_next[2*w +: 2] = wheel_out[w].dir;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            last_heading_reg <= '0;
            wheel_dir_reg    <= '0;
        end else begin
            if (in_load) begin
                in_valid_reg <= 1'b1;
            end else if (out_load) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg    <= 1'b1;
                last_heading_reg <= last_heading_next;
                wheel_dir_reg    <= wheel_dir_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            first_byte_reg  <= s_first_byte;
            second_byte_reg <= s_second_byte;
        end
        if (out_load) begin
            err_reg  <= err_next;
            prop_reg <= prop_full[hhxm_pkg::PROP_W-1:0];
            for (int w = 0; w < 4; w++) begin
                duty_reg[w] <= wheel_out[w].duty;
            end
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_heading_error     = err_reg;
    assign m_proportional_term = prop_reg;
    assign m_duty_top_left     = duty_reg[0];
    assign m_duty_top_right    = duty_reg[1];
    assign m_duty_bottom_left  = duty_reg[2];
    assign m_duty_bottom_right = duty_reg[3];
    assign m_direction_bits    = wheel_dir_reg;

`ifndef SYNTHESIS
    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        last_heading_reg <= HEAD_MAX)
        else $error("stored heading above full turn");

    a_dir_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wheel_dir_reg[0] && wheel_dir_reg[1]) && !(wheel_dir_reg[2] && wheel_dir_reg[3]) &&
        !(wheel_dir_reg[4] && wheel_dir_reg[5]) && !(wheel_dir_reg[6] && wheel_dir_reg[7]))
        else $error("wheel driven forward and reverse at once");

    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_heading_error >= -E_HALF && m_heading_error <= E_HALF))
        else $error("heading error outside half turn");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(last_heading_reg) && $stable(wheel_dir_reg)))
        else $error("state advanced while result stalled");
`endif

endmodule

>>> verif/tb_top.sv
module tb_top;
    import hhxm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = 3'd7;
    localparam int PHASE_COUNT  = 14;
    localparam int PHASE_ITEMS  = 100;
    localparam int QUIET_CYCLES = 6;

    typedef struct packed {
        logic signed [ERR_W-1:0]  heading_error;
        logic signed [PROP_W-1:0] proportional_term;
        logic [DUTY_W-1:0]        duty_top_left;
        logic [DUTY_W-1:0]        duty_top_right;
        logic [DUTY_W-1:0]        duty_bottom_left;
        logic [DUTY_W-1:0]        duty_bottom_right;
        logic [DIR_W-1:0]         direction_bits;
    } mixer_result_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_CONFIG} row_kind_t;
    typedef enum logic [1:0] {RDY_ALWAYS, RDY_MOSTLY, RDY_EVERY_FOURTH, RDY_RARELY} ready_mode_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] cfg_index;
        logic [CFG_DAT_W-1:0] cfg_value;
        logic [BYTE_W-1:0]    first_byte;
        logic [BYTE_W-1:0]    second_byte;
        mixer_result_t        typed_result;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata     = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_first_byte  = '0;
    logic [BYTE_W-1:0]    s_second_byte = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic signed [ERR_W-1:0]  m_heading_error;
    logic signed [PROP_W-1:0] m_proportional_term;
    logic [DUTY_W-1:0]    m_duty_top_left;
    logic [DUTY_W-1:0]    m_duty_top_right;
    logic [DUTY_W-1:0]    m_duty_bottom_left;
    logic [DUTY_W-1:0]    m_duty_bottom_right;
    logic [DIR_W-1:0]     m_direction_bits;

    heading_hold_xdrive_mixer_unit u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_first_byte        (s_first_byte),
        .s_second_byte       (s_second_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_heading_error     (m_heading_error),
        .m_proportional_term (m_proportional_term),
        .m_duty_top_left     (m_duty_top_left),
        .m_duty_top_right    (m_duty_top_right),
        .m_duty_bottom_left  (m_duty_bottom_left),
        .m_duty_bottom_right (m_duty_bottom_right),
        .m_direction_bits    (m_direction_bits)
    );

    logic [HEADING_W-1:0]    set_target   = RST_TARGET_HEADING;
    logic [GAIN_W-1:0]       set_gain     = RST_PROPORTIONAL_GAIN;
    logic signed [CMD_W-1:0] set_forward  = RST_FORWARD_COMMAND;
    logic signed [CMD_W-1:0] set_sideways = RST_SIDEWAYS_COMMAND;
    logic [DB_W-1:0]         set_deadband = RST_DEADBAND;
    int                      held_heading    = 0;
    logic [DIR_W-1:0]        held_directions = '0;

    mixer_result_t pending_results[$];
    stim_row_t     directed_rows[$];
    int            mismatch_count = 0;
    int            burst_left     = 8;
    int            cycle_count    = 0;
    ready_mode_t   ready_mode     = RDY_ALWAYS;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic mixer_result_t predict_mix(logic [BYTE_W-1:0] fb, logic [BYTE_W-1:0] sb);
        mixer_result_t r;
        int hd, tgt, err, f, s, db, sp, mag;
        int spd[4];
        logic [DUTY_W-1:0] duty[4];
        hd = held_heading;
        if (fb != 0 && sb == 0) hd = int'(fb) + HIGH_OFFSET;
        else if (fb == 0 && sb != 0) hd = int'(sb);
        else if (fb == 0 && sb == 0) hd = 0;
        if (hd > HEADING_MAX) hd = held_heading;
        held_heading = hd;

        tgt = int'(set_target);
        if (tgt > HEADING_MAX) tgt = HEADING_MAX;
        err = tgt - hd;
        if (err >= HALF_TURN && err <= FULL_TURN) err -= FULL_TURN;
        else if (err <= -HALF_TURN && err >= -FULL_TURN) err += FULL_TURN;

        f  = set_forward;
        s  = set_sideways;
        db = int'(set_deadband);
        spd[0] = f + s + err;
        spd[1] = -f + s + err;
        spd[2] = f - s + err;
        spd[3] = -f - s + err;
        for (int w = 0; w < 4; w++) begin
            sp = spd[w];
            if (sp > SPEED_LIMIT) sp = SPEED_LIMIT;
            if (sp < LOW_LIMIT) sp = LOW_LIMIT;
            mag = (sp < 0) ? -sp : sp;
            if (sp > db) begin
                held_directions[2*w]   = 1'b1;
                held_directions[2*w+1] = 1'b0;
            end else if (sp < -db) begin
                held_directions[2*w]   = 1'b0;
                held_directions[2*w+1] = 1'b1;
            end
            if (mag > DUTY_MAX) mag = DUTY_MAX;
            duty[w] = mag[DUTY_W-1:0];
        end

        r.heading_error     = err[ERR_W-1:0];
        r.proportional_term = PROP_W'(err * int'(set_gain));
        r.duty_top_left     = duty[0];
        r.duty_top_right    = duty[1];
        r.duty_bottom_left  = duty[2];
        r.duty_bottom_right = duty[3];
        r.direction_bits    = held_directions;
        return r;
    endfunction

    function automatic stim_row_t item_row(int fb, int sb);
        stim_row_t row;
        row = '0;
        row.kind        = ROW_ITEM;
        row.first_byte  = fb[BYTE_W-1:0];
        row.second_byte = sb[BYTE_W-1:0];
        return row;
    endfunction

    function automatic stim_row_t checked_row(int fb, int sb, int err, int prop,
                                              int tl, int tr, int bl, int br, int dir);
        stim_row_t row;
        row = item_row(fb, sb);
        row.kind = ROW_CHECKED;
        row.typed_result.heading_error     = err[ERR_W-1:0];
        row.typed_result.proportional_term = prop[PROP_W-1:0];
        row.typed_result.duty_top_left     = tl[DUTY_W-1:0];
        row.typed_result.duty_top_right    = tr[DUTY_W-1:0];
        row.typed_result.duty_bottom_left  = bl[DUTY_W-1:0];
        row.typed_result.duty_bottom_right = br[DUTY_W-1:0];
        row.typed_result.direction_bits    = dir[DIR_W-1:0];
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int value);
        stim_row_t row;
        row = '0;
        row.kind      = ROW_CONFIG;
        row.cfg_index = idx;
        row.cfg_value = value[CFG_DAT_W-1:0];
        return row;
    endfunction

    task automatic flag_field(string name, int want, int got);
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : result_check
        mixer_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_heading_error !== want.heading_error)
                    flag_field("heading_error", want.heading_error, m_heading_error);
                if (m_proportional_term !== want.proportional_term)
                    flag_field("proportional_term", want.proportional_term,
                               m_proportional_term);
                if (m_duty_top_left !== want.duty_top_left)
                    flag_field("duty_top_left", want.duty_top_left, m_duty_top_left);
                if (m_duty_top_right !== want.duty_top_right)
                    flag_field("duty_top_right", want.duty_top_right, m_duty_top_right);
                if (m_duty_bottom_left !== want.duty_bottom_left)
                    flag_field("duty_bottom_left", want.duty_bottom_left,
                               m_duty_bottom_left);
                if (m_duty_bottom_right !== want.duty_bottom_right)
                    flag_field("duty_bottom_right", want.duty_bottom_right,
                               m_duty_bottom_right);
                if (m_direction_bits !== want.direction_bits)
                    flag_field("direction_bits", want.direction_bits, m_direction_bits);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 128 == 0) ready_mode <= ready_mode_t'($urandom_range(0, 3));
        case (ready_mode)
            RDY_ALWAYS:       m_ready <= 1'b1;
            RDY_MOSTLY:       m_ready <= ($urandom_range(0, 9) < 7);
            RDY_EVERY_FOURTH: m_ready <= (cycle_count % 4 == 3);
            default:          m_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    task automatic send_item(logic [BYTE_W-1:0] fb, logic [BYTE_W-1:0] sb,
                             logic use_typed, mixer_result_t typed);
        mixer_result_t predicted;
        s_valid       <= 1'b1;
        s_first_byte  <= fb;
        s_second_byte <= sb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_mix(fb, sb);
        pending_results.push_back(use_typed ? typed : predicted);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_TARGET_HEADING:    set_target   = value;
            REG_PROPORTIONAL_GAIN: set_gain     = value[GAIN_W-1:0];
            REG_FORWARD_COMMAND:   set_forward  = value;
            REG_SIDEWAYS_COMMAND:  set_sideways = value;
            REG_DEADBAND:          set_deadband = value[DB_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(int phase);
        logic [BYTE_W-1:0]    fb, sb;
        logic [CFG_IDX_W-1:0] junk_idx;
        int                   pick;
        wait_drained();
        case (phase)
            0: begin
                write_reg(REG_TARGET_HEADING, 9'd0);
                write_reg(REG_PROPORTIONAL_GAIN, 9'd0);
                write_reg(REG_FORWARD_COMMAND, 9'h100);
                write_reg(REG_SIDEWAYS_COMMAND, 9'h100);
                write_reg(REG_DEADBAND, 9'd0);
            end
            1: begin
                write_reg(REG_TARGET_HEADING, 9'h1FF);
                write_reg(REG_PROPORTIONAL_GAIN, 9'd255);
                write_reg(REG_FORWARD_COMMAND, 9'd255);
                write_reg(REG_SIDEWAYS_COMMAND, 9'd255);
                write_reg(REG_DEADBAND, 9'd255);
            end
            default: begin
                write_reg(REG_TARGET_HEADING, CFG_DAT_W'(($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, 511) : $urandom_range(0, HEADING_MAX)));
                write_reg(REG_PROPORTIONAL_GAIN, CFG_DAT_W'($urandom_range(0, 255)));
                write_reg(REG_FORWARD_COMMAND, CFG_DAT_W'($urandom_range(0, 511)));
                write_reg(REG_SIDEWAYS_COMMAND, CFG_DAT_W'($urandom_range(0, 511)));
                write_reg(REG_DEADBAND, CFG_DAT_W'(($urandom_range(0, 1) == 0) ?
                          $urandom_range(0, 20) : $urandom_range(0, 255)));
                if ($urandom_range(0, 2) == 0) begin
                    junk_idx = CFG_IDX_W'($urandom_range(REG_UNUSED_LOW, REG_UNUSED_HIGH));
                    write_reg(junk_idx, CFG_DAT_W'($urandom_range(0, 511)));
                end
            end
        endcase
        cfg_wr_en <= 1'b0;

        for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            fb   = BYTE_W'($urandom_range(1, 255));
            sb   = BYTE_W'($urandom_range(1, 255));
            if (pick < 30) sb = '0;
            else if (pick < 55) fb = '0;
            else if (pick < 65) begin
                fb = '0;
                sb = '0;
            end else if (pick >= 80) begin
                fb = BYTE_W'($urandom_range(0, 255));
                sb = BYTE_W'($urandom_range(0, 255));
            end
            send_item(fb, sb, 1'b0, '0);
            burst_left--;
            if (burst_left <= 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = ($urandom_range(0, 7) == 0) ?
                             $urandom_range(40, 120) : $urandom_range(1, 16);
            end
        end
    endtask

    initial begin : stimulus
        stim_row_t row;
        directed_rows = '{
            checked_row(0, 0, 0, 0, 100, 100, 100, 100, 8'h99),
            checked_row(0, 90, -90, -270, 10, 190, 10, 190, 8'h99),
            checked_row(105, 0, 0, 0, 100, 100, 100, 100, 8'h99),
            checked_row(106, 0, 0, 0, 100, 100, 100, 100, 8'h99),
            item_row(255, 255),
            item_row(0, 255),
            checked_row(0, 180, 180, 540, 255, 80, 255, 80, 8'h55),
            checked_row(0, 181, 179, 537, 255, 79, 255, 79, 8'h55),
            checked_row(0, 179, -179, -537, 79, 255, 79, 255, 8'hAA),
            checked_row(0, 100, -100, -300, 0, 200, 0, 200, 8'hAA),
            item_row(0, 97),
            item_row(1, 0),
            item_row(128, 128),
            cfg_row(REG_TARGET_HEADING, 511),
            cfg_row(REG_PROPORTIONAL_GAIN, 255),
            cfg_row(REG_FORWARD_COMMAND, 9'h100),
            cfg_row(REG_SIDEWAYS_COMMAND, 255),
            cfg_row(REG_DEADBAND, 255),
            cfg_row(REG_UNUSED_LOW, 9'h1FF),
            item_row(0, 0),
            item_row(0, 180),
            item_row(0, 181),
            cfg_row(REG_UNUSED_HIGH, 0),
            cfg_row(REG_TARGET_HEADING, 361),
            item_row(255, 0)
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CONFIG) begin
                wait_drained();
                write_reg(row.cfg_index, row.cfg_value);
                cfg_wr_en <= 1'b0;
            end else begin
                send_item(row.first_byte, row.second_byte, row.kind == ROW_CHECKED,
                          row.typed_result);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++) run_phase(p);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
